### hw/rtl/addressable_led_pulse_encoder_assert.svh
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_ASSERT_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_ASSERT_SVH

// Checked only while reset is released.
`define ALPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ALPE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/alpe_pkg.sv
package alpe_pkg;

	localparam int LED_MAX      = 64;
	localparam int LED_AW       = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
	localparam int ACTIVE_MAX   = (LED_MAX < 64) ? LED_MAX : 64;
	localparam int BITS_PER_LED = 24;
	localparam int COLOR_W      = 24;
	localparam int BIT_W        = 5;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = 32;
	localparam int OUT_DATA_W   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIT_PERIOD  = 3'd0,
		REG_ZERO_HIGH   = 3'd1,
		REG_ONE_HIGH    = 3'd2,
		REG_LED_COUNT   = 3'd3,
		REG_FRAME_SLOTS = 3'd4
	} cfg_reg_t;

	localparam logic [7:0]  RST_BIT_PERIOD  = 8'd120;
	localparam logic [7:0]  RST_ZERO_HIGH   = 8'd39;
	localparam logic [7:0]  RST_ONE_HIGH    = 8'd77;
	localparam logic [6:0]  RST_LED_COUNT   = 7'd64;
	localparam logic [15:0] RST_FRAME_SLOTS = 16'd40000;

endpackage

### hw/rtl/addressable_led_pulse_encoder.sv
// Channel  | Direction | Content
// s_*      | in        | tuser: kind; tdata: led_index, red, green, blue, pad
// m_*      | out       | tdata: line_level, sending, frame_start, pad
// cfg_*    | in        | register index and write data, no read-back
//
// One item is taken per cycle unless stalled; a tick is registered in s1, then at the output.
// The color store is a 64-entry memory with a registered read; writes and
// tick reads of it come from distinct items, so no forwarding is needed.
// Reset clears all counters and per-entry valid bits; an unwritten entry
// reads as all ones. A stalled output holds the tick pipeline and the input.
module addressable_led_pulse_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [alpe_pkg::IN_DATA_W-1:0]  s_tdata,  // led_index, red, green, blue, zero pad
	input  logic                            s_tuser,  // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [alpe_pkg::OUT_DATA_W-1:0] m_tdata,  // line_level, sending, frame_start, zero pad
	input  logic                            cfg_wr_en,
	input  logic [alpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [alpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import alpe_pkg::*;

	logic [7:0]  bit_period_q, zero_high_q, one_high_q;
	logic [6:0]  led_count_q;
	logic [15:0] frame_slots_q;

	logic [7:0]  tick_q;
	logic [15:0] slot_q;
	logic [BIT_W-1:0] bit_q;
	logic [6:0]  led_q;

	logic [COLOR_W-1:0] mem_q [LED_MAX];
	logic [LED_MAX-1:0] valid_q;

	logic               s1_valid_s1;
	logic [COLOR_W-1:0] rdata_s1;
	logic               entry_ok_s1;
	logic [BIT_W-1:0]   bitsel_s1;
	logic               data_s1, first_s1, below_oh_s1, below_zh_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic        adv, accept, tick_acc, wr_acc;
	logic [7:0]  period, zh, oh;
	logic [15:0] slots;
	logic [6:0]  active;
	logic        data_s0, first_s0, slot_end, frame_end, led_end;
	logic [8:0]  tick_inc;
	logic [16:0] slot_inc;
	logic [BIT_W-1:0] bit_inc;
	logic        bit_s1, level_s1;
	logic [COLOR_W-1:0] wr_color;

	always_comb begin
		adv      = !s1_valid_s1 || !out_valid_q || m_tready;
		s_tready = adv;
		accept   = s_tvalid && adv;
		tick_acc = accept && s_tuser;
		wr_acc   = accept && !s_tuser;

		period = (bit_period_q < 8'd2) ? 8'd2 : bit_period_q;
		zh     = (zero_high_q == 8'd0) ? 8'd1 : zero_high_q;
		oh     = (one_high_q == 8'd0) ? 8'd1 : one_high_q;
		slots  = (frame_slots_q == 16'd0) ? 16'd1 : frame_slots_q;
		active = (led_count_q > 7'(ACTIVE_MAX)) ? 7'(ACTIVE_MAX) : led_count_q;

		data_s0  = (led_q < active) && (bit_q < BIT_W'(BITS_PER_LED));
		first_s0 = (slot_q == 16'd0) && (tick_q == 8'd0);

		tick_inc  = {1'b0, tick_q} + 9'd1;
		slot_end  = tick_inc >= {1'b0, period};
		slot_inc  = {1'b0, slot_q} + 17'd1;
		frame_end = slot_inc >= {1'b0, slots};
		bit_inc   = bit_q + BIT_W'(1);
		led_end   = bit_inc >= BIT_W'(BITS_PER_LED);

		wr_color = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};

		bit_s1   = entry_ok_s1 ? rdata_s1[bitsel_s1] : 1'b1;
		level_s1 = data_s1 && below_oh_s1 && (bit_s1 || below_zh_s1);

		m_tvalid = out_valid_q;
		m_tdata  = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= RST_BIT_PERIOD;
			zero_high_q   <= RST_ZERO_HIGH;
			one_high_q    <= RST_ONE_HIGH;
			led_count_q   <= RST_LED_COUNT;
			frame_slots_q <= RST_FRAME_SLOTS;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_BIT_PERIOD:  bit_period_q  <= cfg_data[7:0];
				REG_ZERO_HIGH:   zero_high_q   <= cfg_data[7:0];
				REG_ONE_HIGH:    one_high_q    <= cfg_data[7:0];
				REG_LED_COUNT:   led_count_q   <= cfg_data[6:0];
				REG_FRAME_SLOTS: frame_slots_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			slot_q <= '0;
			bit_q  <= '0;
			led_q  <= '0;
		end else if (tick_acc) begin
			if (slot_end) begin
				tick_q <= '0;
				if (frame_end) begin
					slot_q <= '0;
					bit_q  <= '0;
					led_q  <= '0;
				end else begin
					slot_q <= slot_inc[15:0];
					if (data_s0) begin
						if (led_end) begin
							bit_q <= '0;
							led_q <= led_q + 7'd1;
						end else begin
							bit_q <= bit_inc;
						end
					end
				end
			end else begin
				tick_q <= tick_inc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_acc) begin
			valid_q[s_tdata[LED_AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			mem_q[s_tdata[LED_AW-1:0]] <= wr_color;
		end
		if (tick_acc) begin
			rdata_s1    <= mem_q[led_q[LED_AW-1:0]];
			entry_ok_s1 <= valid_q[led_q[LED_AW-1:0]];
			bitsel_s1   <= BIT_W'(BITS_PER_LED - 1) - bit_q;
			data_s1     <= data_s0;
			first_s1    <= first_s0;
			below_oh_s1 <= tick_q < oh;
			below_zh_s1 <= tick_q < zh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				s1_valid_s1 <= tick_acc;
			end
			if (!out_valid_q || m_tready) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= {5'd0, first_s1, data_s1, level_s1};
		end
	end

endmodule

### hw/rtl/alpe_checker.sv
`include "addressable_led_pulse_encoder_assert.svh"

module alpe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [alpe_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [alpe_pkg::OUT_DATA_W-1:0] m_tdata
);
	import alpe_pkg::*;

	`ALPE_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`ALPE_ASSERT(a_level_in_data, m_tvalid && m_tdata[0] |-> m_tdata[1], "line high outside data part")
	`ALPE_ASSERT(a_tick_source, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2), "result without a tick request")
	`ALPE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid, "result shown during reset")

endmodule

bind addressable_led_pulse_encoder alpe_checker u_alpe_checker (.*);

### tb/alpe_line_checker.sv
module alpe_line_checker
	import alpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    results,
	output int                    frames
);

	typedef struct packed {
		logic frame_start;
		logic sending;
		logic line_level;
	} pulse_t;

	logic [7:0]         period_reg;
	logic [7:0]         zero_reg;
	logic [7:0]         one_reg;
	logic [6:0]         count_reg;
	logic [15:0]        slots_reg;
	logic [COLOR_W-1:0] colors [LED_MAX];
	logic [7:0]         tick_pos;
	logic [15:0]        slot_pos;
	logic [BIT_W-1:0]   bit_pos;
	logic [6:0]         led_pos;
	pulse_t             pulse_q [$];
	pulse_t             want;
	pulse_t             got;
	int                 mismatches = 0;
	int                 result_count = 0;
	int                 frame_count = 0;
	string              field_name [3] = '{"line_level", "sending", "frame_start"};

	task automatic report(input string what);
		if (mismatches < 20) begin
			$display("mismatch at %0t: %s", $time, what);
		end
		mismatches++;
	endtask

	// Works out the line for one clock tick and moves the waveform on by one tick.
	task automatic step_waveform(output pulse_t p);
		logic [7:0]  period;
		logic [7:0]  zero_hi;
		logic [7:0]  one_hi;
		logic [15:0] slots;
		logic [6:0]  active;
		logic        data;
		logic        bit_val;
		period  = (period_reg < 8'd2) ? 8'd2 : period_reg;
		zero_hi = (zero_reg < 8'd1) ? 8'd1 : zero_reg;
		one_hi  = (one_reg < 8'd1) ? 8'd1 : one_reg;
		slots   = (slots_reg < 16'd1) ? 16'd1 : slots_reg;
		active  = (count_reg > ACTIVE_MAX) ? 7'(ACTIVE_MAX) : count_reg;
		data    = (led_pos < active) && (bit_pos < BITS_PER_LED);
		bit_val = 1'b0;
		if (data) begin
			bit_val = colors[led_pos[LED_AW-1:0]][BITS_PER_LED - 1 - bit_pos];
		end
		p.line_level  = data && (tick_pos < one_hi) && (bit_val || (tick_pos < zero_hi));
		p.sending     = data;
		p.frame_start = (slot_pos == 16'd0) && (tick_pos == 8'd0);
		if (tick_pos + 9'd1 >= period) begin
			tick_pos = 8'd0;
			if (data) begin
				if (bit_pos + 6'd1 >= BITS_PER_LED) begin
					bit_pos = '0;
					led_pos++;
				end else begin
					bit_pos++;
				end
			end
			if (slot_pos + 17'd1 >= slots) begin
				slot_pos = 16'd0;
				bit_pos  = '0;
				led_pos  = 7'd0;
			end else begin
				slot_pos++;
			end
		end else begin
			tick_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_reg = RST_BIT_PERIOD;
			zero_reg   = RST_ZERO_HIGH;
			one_reg    = RST_ONE_HIGH;
			count_reg  = RST_LED_COUNT;
			slots_reg  = RST_FRAME_SLOTS;
			for (int i = 0; i < LED_MAX; i++) begin
				colors[i] = '1;
			end
			tick_pos = 8'd0;
			slot_pos = 16'd0;
			bit_pos  = '0;
			led_pos  = 7'd0;
			pulse_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[2:0];
				result_count++;
				if (pulse_q.size() == 0) begin
					report("line result with no tick waiting");
				end else begin
					want = pulse_q.pop_front();
					if (want.frame_start) begin
						frame_count++;
					end
					for (int f = 0; f < 3; f++) begin
						if (got[f] !== want[f]) begin
							report($sformatf("%s is %b, expected %b (result %0d)",
								field_name[f], got[f], want[f], result_count));
						end
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BIT_PERIOD:  period_reg = cfg_data[7:0];
					REG_ZERO_HIGH:   zero_reg = cfg_data[7:0];
					REG_ONE_HIGH:    one_reg = cfg_data[7:0];
					REG_LED_COUNT:   count_reg = cfg_data[6:0];
					REG_FRAME_SLOTS: slots_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					step_waveform(want);
					pulse_q.push_back(want);
				end else begin
					colors[s_tdata[5:0]] = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
				end
			end
		end
		errors  <= mismatches;
		pending <= pulse_q.size();
		results <= result_count;
		frames  <= frame_count;
	end

endmodule

### tb/tb_addressable_led_pulse_encoder.sv
module tb_addressable_led_pulse_encoder;
	import alpe_pkg::*;

	localparam int ITEM_TARGET = 950;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 4;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int results;
	int frames;
	int cycles = 0;
	int items_sent = 0;
	int settings = 0;
	bit quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	addressable_led_pulse_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	alpe_line_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.results   (results),
		.frames    (frames)
	);

	function automatic int gap();
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_item(input logic kind, input logic [5:0] idx, input logic [23:0] color);
		int n;
		n = gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, color[7:0], color[15:8], color[23:16], idx};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic tick();
		send_item(1'b1, 6'($urandom), 24'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] period, input logic [7:0] zero_hi,
			input logic [7:0] one_hi, input logic [6:0] count, input logic [15:0] slots);
		write_reg(REG_BIT_PERIOD, {8'($urandom), period});
		write_reg(REG_ZERO_HIGH, {8'($urandom), zero_hi});
		write_reg(REG_ONE_HIGH, {8'($urandom), one_hi});
		write_reg(REG_LED_COUNT, {9'($urandom), count});
		write_reg(REG_FRAME_SLOTS, slots);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic pick_setting(input int phase);
		int p;
		int z;
		int o;
		int c;
		int s;
		case (phase)
			0: apply_setting(8'd0, 8'd1, 8'd1, 7'd1, 16'd30);
			1: apply_setting(8'd3, 8'd0, 8'd2, 7'd2, 16'd0);
			2: apply_setting(8'd4, 8'd3, 8'd2, 7'd1, 16'd26);
			3: apply_setting(8'd2, 8'd255, 8'd255, 7'd127, 16'd65535);
			4: apply_setting(8'd255, 8'd255, 8'd1, 7'd64, 16'd65535);
			5: apply_setting(8'd5, 8'd1, 8'd4, 7'd0, 16'd3);
			6: apply_setting(8'd1, 8'd1, 8'd2, 7'd3, 16'd20);
			default: begin
				p = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 255) : $urandom_range(2, 6);
				z = $urandom_range(0, (p < 254) ? p + 1 : 255);
				o = $urandom_range(0, (p < 254) ? p + 1 : 255);
				c = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 3);
				s = $urandom_range(0, ((c < 4) ? c : 4) * 24 + 8);
				apply_setting(8'(p), 8'(z), 8'(o), 7'(c), 16'(s));
			end
		endcase
	endtask

	task automatic run_phase(input int count, input bit pause_midway);
		logic [5:0]  idx;
		logic [23:0] color;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				drain();
			end
			if ($urandom_range(0, 6) == 0) begin
				idx = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
				case ($urandom_range(0, 5))
					0: color = '0;
					1: color = '1;
					default: color = 24'($urandom);
				endcase
				send_item(1'b0, idx, color);
			end else begin
				tick();
			end
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			int n;
			n = gap();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
			$display("FAIL addressable_led_pulse_encoder");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes at the reset setting, then a short frame with a led count of three.
		send_item(1'b0, 6'd0, 24'h000000);
		send_item(1'b0, 6'd63, 24'hFFFFFF);
		send_item(1'b0, 6'd1, 24'hA5C35A);
		send_item(1'b0, 6'd2, 24'h5A3CA5);
		repeat (4) tick();
		drain();
		apply_setting(8'd3, 8'd1, 8'd2, 7'd3, 16'd4);
		repeat (16) tick();
		drain();

		for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
			pick_setting(phase);
			quiet = ($urandom_range(0, 3) == 0);
			run_phase($urandom_range(40, 140), phase == 2);
			drain();
		end

		$display("%0d requests under %0d register settings (saturated and extreme values too),",
			items_sent, settings);
		$display("%0d line levels checked over %0d frame starts", results, frames);
		if (errors == 0 && pending == 0) begin
			$display("PASS addressable_led_pulse_encoder");
		end else begin
			$display("FAIL addressable_led_pulse_encoder");
		end
		$finish;
	end

endmodule
